FILE: rtl/diffusion_tridiagonal_row_builder_assert.svh
// Assertion macros for the row builder controller RTL.
// Expects signals named clk and rst_n in the including scope.
`ifndef DIFFUSION_TRIDIAGONAL_ROW_BUILDER_ASSERT_SVH
`define DIFFUSION_TRIDIAGONAL_ROW_BUILDER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DTRB_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dtrb assertion failed");

// Next-cycle implication, checked outside reset.
`define DTRB_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtrb assertion failed");

`endif

FILE: rtl/dtrb_pkg.sv
// Shared types and constants of the tridiagonal row builder.
// No dependencies; imported by the interfaces and every module.
`timescale 1ns / 1ps

package dtrb_pkg;

  localparam int CONC_W     = 47;   // concentrations and register values
  localparam int COEF_W     = 48;   // signed result coefficients
  localparam int ROW_W      = 12;   // row index field
  localparam int HALF_W     = 24;   // multiplier operand slice
  localparam int MUL_W      = 2 * HALF_W;
  localparam int ACC_W      = 98;   // holds three signed 95-bit products
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 64;

  localparam logic [3:0] C3_LAST_STEP  = 4'd3;   // one product, four slices
  localparam logic [3:0] RHS_LAST_STEP = 4'd11;  // three products, four slices

  localparam logic [CONC_W-1:0] CONC_MAX = '1;

  localparam logic [CONC_W-1:0] INV_DT_RESET = CONC_W'(65536);

  // Product term codes within a right-hand-side phase
  localparam logic [1:0] TERM_PREV = 2'd0;
  localparam logic [1:0] TERM_NEXT = 2'd1;
  localparam logic [1:0] TERM_CUR  = 2'd2;

  typedef enum logic [1:0] {
    PH_C3,
    PH_RHS_A,
    PH_RHS_B
  } dtrb_phase_t;

  typedef enum logic [1:0] {
    K_FIRST,
    K_INT,
    K_LAST
  } dtrb_kind_t;

  typedef struct packed {
    logic             load;     // input transaction accepted
    logic             mac_en;   // issue one partial product
    logic [1:0]       term;
    logic             half_a;
    logic             half_b;
    dtrb_phase_t      phase;
    logic             cap;      // latch phase result, clear accumulator
    logic             coef;     // form diagonal and center weight
    logic             emit;     // load the output register
    dtrb_kind_t       kind;
    logic [ROW_W-1:0] row;
  } dtrb_cmd_t;

endpackage

FILE: rtl/dtrb_if.sv
// Valid/ready channel interfaces for grid points and result rows.
// Depends on dtrb_pkg for field widths.
`timescale 1ns / 1ps

interface dtrb_in_if;
  import dtrb_pkg::*;

  logic              valid;
  logic              ready;
  logic [CONC_W-1:0] conc_a;
  logic [CONC_W-1:0] conc_b;

  modport source (output valid, conc_a, conc_b, input ready);
  modport sink   (input valid, conc_a, conc_b, output ready);
endinterface

interface dtrb_out_if;
  import dtrb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ROW_W-1:0]         row_index;
  logic signed [COEF_W-1:0] lower_coeff;
  logic signed [COEF_W-1:0] diag_coeff;
  logic signed [COEF_W-1:0] upper_coeff;
  logic signed [COEF_W-1:0] rhs_a;
  logic signed [COEF_W-1:0] rhs_b;
  logic                     last_row;

  modport source (output valid, row_index, lower_coeff, diag_coeff, upper_coeff,
                  rhs_a, rhs_b, last_row, input ready);
  modport sink   (input valid, row_index, lower_coeff, diag_coeff, upper_coeff,
                  rhs_a, rhs_b, last_row, output ready);
endinterface

FILE: rtl/dtrb_datapath.sv
// Datapath: point window, ratio table, shared multiply-accumulate, result registers.
// Depends on dtrb_pkg; driven only by commands from dtrb_ctrl.
`timescale 1ns / 1ps

module dtrb_datapath #(
  parameter int GRID_POINTS = 256,
  parameter int FRAC_BITS   = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dtrb_pkg::dtrb_cmd_t                cmd,
  input  logic [dtrb_pkg::CONC_W-1:0]        conc_a,
  input  logic [dtrb_pkg::CONC_W-1:0]        conc_b,
  input  logic [dtrb_pkg::CONC_W-1:0]        diff_coeff,
  input  logic [dtrb_pkg::CONC_W-1:0]        inv_dt,
  output logic [dtrb_pkg::ROW_W-1:0]         row_index,
  output logic signed [dtrb_pkg::COEF_W-1:0] lower_coeff,
  output logic signed [dtrb_pkg::COEF_W-1:0] diag_coeff,
  output logic signed [dtrb_pkg::COEF_W-1:0] upper_coeff,
  output logic signed [dtrb_pkg::COEF_W-1:0] rhs_a,
  output logic signed [dtrb_pkg::COEF_W-1:0] rhs_b,
  output logic                               last_row
);
  import dtrb_pkg::*;

  localparam int CNT_W   = $clog2(GRID_POINTS);
  localparam int RATIO_W = FRAC_BITS + 3;

  localparam logic signed [COEF_W-1:0] ONE = COEF_W'(1) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'({1'b0, {(COEF_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] C3_HI  = ACC_W'(CONC_MAX);

  // Radial ratio table ((i+1)/i)^2, built at elaboration
  logic [RATIO_W-1:0] ratio_rom [GRID_POINTS];

  for (genvar g = 0; g < GRID_POINTS; g++) begin : g_ratio
    localparam longint unsigned Num = longint'((g + 1) * (g + 1)) << FRAC_BITS;
    localparam longint unsigned Den = (g == 0) ? 1 : longint'(g * g);
    localparam longint unsigned Quot = Num / Den;
    assign ratio_rom[g] = RATIO_W'(Quot);
  end

  // Window: w0 = point k-2, w1 = point k-1, w2 = point k
  logic [CONC_W-1:0]  w0_a_r, w1_a_r, w2_a_r;
  logic [CONC_W-1:0]  w0_b_r, w1_b_r, w2_b_r;
  logic [RATIO_W-1:0] ratio_r;

  logic [CONC_W-1:0]  c3_r;
  logic [CONC_W-1:0]  diag_r;
  logic [MUL_W-1:0]   diff_r;
  logic               diff_neg_r;
  logic [COEF_W-1:0]  rhs_a_r, rhs_b_r;

  logic [MUL_W-1:0]   pp_r;
  logic [1:0]         pp_sh_r;
  logic               pp_neg_r;
  logic               pp_vld_r;
  logic signed [ACC_W-1:0] acc_r;

  logic [MUL_W-1:0]   op_a, op_b;
  logic [HALF_W-1:0]  a_half, b_half;
  logic               op_neg;
  logic [MUL_W-1:0]   pp_nxt;
  logic signed [ACC_W-1:0] pp_ext, acc_nxt, acc_shr;
  logic [COEF_W-1:0]  rhs_sat;
  logic [CONC_W-1:0]  c3_sat;
  logic [MUL_W-1:0]   s_sum;
  logic [CONC_W+1:0]  d_sum;

  // Operand selection for the shared multiplier
  always_comb begin
    op_a = MUL_W'(diff_coeff);
    op_b = MUL_W'(ratio_r);
    if (cmd.phase != PH_C3) begin
      unique case (cmd.term)
        TERM_PREV: op_a = MUL_W'(diff_coeff);
        TERM_NEXT: op_a = MUL_W'(c3_r);
        default:   op_a = diff_r;
      endcase
      if (cmd.phase == PH_RHS_A) begin
        unique case (cmd.term)
          TERM_PREV: op_b = MUL_W'(w0_a_r);
          TERM_NEXT: op_b = MUL_W'(w2_a_r);
          default:   op_b = MUL_W'(w1_a_r);
        endcase
      end else begin
        unique case (cmd.term)
          TERM_PREV: op_b = MUL_W'(w0_b_r);
          TERM_NEXT: op_b = MUL_W'(w2_b_r);
          default:   op_b = MUL_W'(w1_b_r);
        endcase
      end
    end
  end

  assign op_neg = (cmd.phase != PH_C3) && (cmd.term == TERM_CUR) && diff_neg_r;
  assign a_half = cmd.half_a ? op_a[MUL_W-1:HALF_W] : op_a[HALF_W-1:0];
  assign b_half = cmd.half_b ? op_b[MUL_W-1:HALF_W] : op_b[HALF_W-1:0];
  assign pp_nxt = MUL_W'(a_half) * MUL_W'(b_half);

  // Align the registered partial product to its slice weight
  always_comb begin
    unique case (pp_sh_r)
      2'd0:    pp_ext = ACC_W'(pp_r);
      2'd1:    pp_ext = ACC_W'(pp_r) << HALF_W;
      default: pp_ext = ACC_W'(pp_r) << (2 * HALF_W);
    endcase
    acc_nxt = pp_neg_r ? (acc_r - pp_ext) : (acc_r + pp_ext);
  end

  // Truncating shift and saturation of the accumulated sum
  assign acc_shr = acc_r >>> FRAC_BITS;

  always_comb begin
    if (acc_shr > SAT_HI) begin
      rhs_sat = SAT_HI[COEF_W-1:0];
    end else if (acc_shr < SAT_LO) begin
      rhs_sat = SAT_LO[COEF_W-1:0];
    end else begin
      rhs_sat = acc_shr[COEF_W-1:0];
    end
    c3_sat = (acc_shr > C3_HI) ? CONC_MAX : acc_shr[CONC_W-1:0];
  end

  assign s_sum = MUL_W'(diff_coeff) + MUL_W'(c3_r);
  assign d_sum = (CONC_W+2)'(diff_coeff) + (CONC_W+2)'(inv_dt) + (CONC_W+2)'(c3_r);

  // Window and ratio load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w0_a_r <= '0;
      w1_a_r <= '0;
      w2_a_r <= '0;
      w0_b_r <= '0;
      w1_b_r <= '0;
      w2_b_r <= '0;
    end else if (cmd.load) begin
      w0_a_r <= w1_a_r;
      w1_a_r <= w2_a_r;
      w2_a_r <= conc_a;
      w0_b_r <= w1_b_r;
      w1_b_r <= w2_b_r;
      w2_b_r <= conc_b;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ratio_r <= ratio_rom[cmd.row[CNT_W-1:0]];
    end
  end

  // Multiply stage then accumulate stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_vld_r <= 1'b0;
      acc_r    <= '0;
    end else begin
      pp_vld_r <= cmd.mac_en;
      if (cmd.cap) begin
        acc_r <= '0;
      end else if (pp_vld_r) begin
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      pp_r     <= pp_nxt;
      pp_sh_r  <= {1'b0, cmd.half_a} + {1'b0, cmd.half_b};
      pp_neg_r <= op_neg;
    end
  end

  // Phase results and derived coefficients
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      unique case (cmd.phase)
        PH_C3:    c3_r    <= c3_sat;
        PH_RHS_A: rhs_a_r <= rhs_sat;
        PH_RHS_B: rhs_b_r <= rhs_sat;
        default:  rhs_b_r <= rhs_sat;
      endcase
    end
    if (cmd.coef) begin
      if (s_sum >= MUL_W'(inv_dt)) begin
        diff_r     <= s_sum - MUL_W'(inv_dt);
        diff_neg_r <= 1'b1;
      end else begin
        diff_r     <= MUL_W'(inv_dt) - s_sum;
        diff_neg_r <= 1'b0;
      end
      diag_r <= (d_sum > (CONC_W+2)'(CONC_MAX)) ? CONC_MAX : d_sum[CONC_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      row_index <= cmd.row;
      unique case (cmd.kind)
        K_FIRST: begin
          lower_coeff <= '0;
          diag_coeff  <= ONE;
          upper_coeff <= -ONE;
          rhs_a       <= '0;
          rhs_b       <= '0;
          last_row    <= 1'b0;
        end
        K_INT: begin
          lower_coeff <= -COEF_W'(diff_coeff);
          diag_coeff  <= COEF_W'(diag_r);
          upper_coeff <= -COEF_W'(c3_r);
          rhs_a       <= rhs_a_r;
          rhs_b       <= rhs_b_r;
          last_row    <= 1'b0;
        end
        default: begin
          lower_coeff <= -ONE;
          diag_coeff  <= ONE;
          upper_coeff <= '0;
          rhs_a       <= '0;
          rhs_b       <= '0;
          last_row    <= 1'b1;
        end
      endcase
    end
  end

endmodule

FILE: rtl/dtrb_ctrl.sv
// Controller: point counter and sequencer for the multiply-accumulate phases.
// Depends on dtrb_pkg and the assertion macro header; drives dtrb_datapath.
`timescale 1ns / 1ps
`include "diffusion_tridiagonal_row_builder_assert.svh"

module dtrb_ctrl #(
  parameter int GRID_POINTS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output dtrb_pkg::dtrb_cmd_t cmd
);
  import dtrb_pkg::*;

  localparam int CNT_W = $clog2(GRID_POINTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_CAP,
    S_COEF,
    S_EMIT1,
    S_EMIT2
  } state_t;

  state_t            state_r;
  dtrb_phase_t       phase_r;
  dtrb_kind_t        kind_r;
  logic [3:0]        step_r;
  logic [CNT_W-1:0]  point_cnt_r;
  logic [CNT_W-1:0]  item_k_r;
  logic              out_valid_r;

  logic              accept;
  logic              slot_free;
  logic [3:0]        last_step;
  logic [CNT_W-1:0]  point_cnt_nxt;
  logic              grid_end;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign last_step = (phase_r == PH_C3) ? C3_LAST_STEP : RHS_LAST_STEP;
  assign grid_end  = (item_k_r == CNT_W'(GRID_POINTS - 1));

  assign point_cnt_nxt = (({1'b0, point_cnt_r} + (CNT_W+1)'(1)) >= (CNT_W+1)'(GRID_POINTS))
                         ? '0 : point_cnt_r + CNT_W'(1);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd        = '0;
    cmd.load   = accept;
    cmd.mac_en = (state_r == S_MAC);
    cmd.term   = step_r[3:2];
    cmd.half_a = step_r[0];
    cmd.half_b = step_r[1];
    cmd.phase  = phase_r;
    cmd.cap    = (state_r == S_CAP);
    cmd.coef   = (state_r == S_COEF);
    cmd.emit   = ((state_r == S_EMIT1) || (state_r == S_EMIT2)) && slot_free;
    cmd.kind   = (state_r == S_EMIT2) ? K_LAST : kind_r;
    priority if (state_r == S_EMIT2) begin
      cmd.row = ROW_W'(item_k_r);
    end else if (state_r == S_EMIT1 && kind_r == K_FIRST) begin
      cmd.row = '0;
    end else if (state_r == S_EMIT1) begin
      cmd.row = ROW_W'(item_k_r) - ROW_W'(1);
    end else begin
      // row of the arriving point, addresses the ratio table
      cmd.row = ROW_W'(point_cnt_r) - ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_C3;
      kind_r      <= K_FIRST;
      step_r      <= '0;
      point_cnt_r <= '0;
      item_k_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            point_cnt_r <= point_cnt_nxt;
            item_k_r    <= point_cnt_r;
            if (point_cnt_r == '0) begin
              kind_r  <= K_FIRST;
              state_r <= S_EMIT1;
            end else if (point_cnt_r != CNT_W'(1)) begin
              phase_r <= PH_C3;
              step_r  <= '0;
              state_r <= S_MAC;
            end
          end
        end
        S_MAC: begin
          step_r <= step_r + 4'd1;
          if (step_r == last_step) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_CAP;
        end
        S_CAP: begin
          unique case (phase_r)
            PH_C3: begin
              state_r <= S_COEF;
            end
            PH_RHS_A: begin
              phase_r <= PH_RHS_B;
              step_r  <= '0;
              state_r <= S_MAC;
            end
            default: begin
              kind_r  <= K_INT;
              state_r <= S_EMIT1;
            end
          endcase
        end
        S_COEF: begin
          phase_r <= PH_RHS_A;
          step_r  <= '0;
          state_r <= S_MAC;
        end
        S_EMIT1: begin
          if (slot_free) begin
            state_r <= (kind_r == K_INT && grid_end) ? S_EMIT2 : S_IDLE;
          end
        end
        S_EMIT2: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // The second point of a grid yields no row
  `DTRB_ASSERT_NXT(a_second_point_silent, accept && point_cnt_r == CNT_W'(1), state_r == S_IDLE)
  // A phase result is latched only after the accumulator has drained
  `DTRB_ASSERT_IMP(a_cap_after_drain, state_r == S_CAP, $past(state_r) == S_DRAIN)
  // The closing boundary row follows an interior row of the last point
  `DTRB_ASSERT_IMP(a_last_row_order, state_r == S_EMIT2 && $past(state_r) != S_EMIT2,
                   $past(state_r) == S_EMIT1 && $past(kind_r) == K_INT && grid_end)
  // The point counter wraps before reaching the grid size
  `DTRB_ASSERT_IMP(a_count_range, 1'b1, point_cnt_r < CNT_W'(GRID_POINTS - 1) ||
                   point_cnt_r == CNT_W'(GRID_POINTS - 1))

endmodule

FILE: rtl/diffusion_tridiagonal_row_builder.sv
// Crank-Nicolson tridiagonal row builder, top level: register port and wiring.
// Depends on dtrb_pkg, dtrb_if, dtrb_ctrl and dtrb_datapath.
`timescale 1ns / 1ps

// Radial grid points (species A and B concentrations, Q.FRAC_BITS) enter one
// transaction at a time, center first, and each produces the tridiagonal row of
// the point before it: shared lower, diagonal and upper coefficients plus one
// right-hand side per species, truncated and saturated to signed 48 bits. The
// first point of a grid returns the zero-flux row 0 at once, the second returns
// nothing, and the last returns row GRID_POINTS-2 followed by the closing
// boundary row flagged by last_row; the next point then starts a new grid with
// the window kept. An interior point holds the block from acceptance through
// the C3 phase, the coefficient step, the right-hand-side phases for species A
// and B and the row emit: seven products of operands up to 48 bits share one
// 24x24 multiply-accumulate unit, four partial products each, with a drain and
// capture step after every phase. The last point also loads the closing row
// after the interior row, the first loads row 0 in the emit state entered on
// acceptance, and the second returns straight to idle. Output stalls hold the
// sequencer only while a row waits to enter an occupied output register.
// in_ready is high while the sequencer is idle; a finished row waits in the
// output register while the next point is accepted. Registers sit at byte
// address 0 (diffusion_coeff) and 8 (inv_time_step), selected by paddr[3];
// write them only while the block is idle. pready is tied high.

module diffusion_tridiagonal_row_builder #(
  parameter int GRID_POINTS = 256,
  parameter int FRAC_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  dtrb_in_if.sink                           in_ch,
  dtrb_out_if.source                        out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dtrb_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [dtrb_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [dtrb_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import dtrb_pkg::*;

  logic [CONC_W-1:0] diff_coeff_r;
  logic [CONC_W-1:0] inv_dt_r;
  logic              cfg_write;
  dtrb_cmd_t         cmd;

  // Register port: zero-wait APB, paddr[3] picks the register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_coeff_r <= '0;
      inv_dt_r     <= INV_DT_RESET;
    end else if (cfg_write) begin
      // drop bits above the register width
      if (paddr[3]) begin
        inv_dt_r <= pwdata[CONC_W-1:0];
      end else begin
        diff_coeff_r <= pwdata[CONC_W-1:0];
      end
    end
  end

  assign prdata = paddr[3] ? APB_DATA_W'(inv_dt_r) : APB_DATA_W'(diff_coeff_r);

  // Sequencer: accepts points, steps the shared MAC, paces the output register
  dtrb_ctrl #(
    .GRID_POINTS (GRID_POINTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Arithmetic: window, ratio table, multiply-accumulate, output register
  dtrb_datapath #(
    .GRID_POINTS (GRID_POINTS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .conc_a      (in_ch.conc_a),
    .conc_b      (in_ch.conc_b),
    .diff_coeff  (diff_coeff_r),
    .inv_dt      (inv_dt_r),
    .row_index   (out_ch.row_index),
    .lower_coeff (out_ch.lower_coeff),
    .diag_coeff  (out_ch.diag_coeff),
    .upper_coeff (out_ch.upper_coeff),
    .rhs_a       (out_ch.rhs_a),
    .rhs_b       (out_ch.rhs_b),
    .last_row    (out_ch.last_row)
  );

endmodule

FILE: dv/tb.sv
// Self-checking testbench for diffusion_tridiagonal_row_builder.
// Predicts every Crank-Nicolson row from the grid points it sends and checks each result row.
// Depends on dtrb_pkg, dtrb_if and the row builder RTL.
`timescale 1ns / 1ps

module tb;
  import dtrb_pkg::*;

  localparam int GRID = 256;
  localparam int FRAC = 16;
  localparam int RANDOM_TARGET = 1000;  // minimum grid points sent in all, directed ones included
  localparam int TAIL_CYCLES = 48;      // longest row latency plus margin

  localparam int REG_DIFFUSION = 0;
  localparam int REG_INV_DT    = 1;

  localparam logic [CONC_W-1:0] CONC_TOP = '1;
  localparam logic [COEF_W-1:0] ONE_Q = COEF_W'(1) << FRAC;
  localparam logic signed [127:0] SAT_HI = (128'sd1 <<< 47) - 128'sd1;
  localparam logic signed [127:0] SAT_LO = -(128'sd1 <<< 47);

  typedef enum {
    CFG_TYPICAL,
    CFG_RANDOM,
    CFG_ALL_MAX,
    CFG_ALL_ZERO,
    CFG_HIGH_DIFFUSION,
    CFG_HIGH_INV_DT
  } cfg_profile_t;

  typedef struct {
    logic [ROW_W-1:0]  row;
    logic [COEF_W-1:0] lower;
    logic [COEF_W-1:0] diag;
    logic [COEF_W-1:0] upper;
    logic [COEF_W-1:0] rhs_a;
    logic [COEF_W-1:0] rhs_b;
    logic              last;
  } cn_row_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  dtrb_in_if  in_ch ();
  dtrb_out_if out_ch ();

  diffusion_tridiagonal_row_builder #(
    .GRID_POINTS(GRID),
    .FRAC_BITS  (FRAC)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Predictor state: register copies and the two-point concentration window
  logic [CONC_W-1:0] diff_coeff;
  logic [CONC_W-1:0] inv_dt;
  logic [CONC_W-1:0] a_older, a_newer, b_older, b_newer;
  int                next_point;
  int                grids_done;

  cn_row_t rows_due[$];
  cn_row_t row_want;
  int      mismatch_count;
  int      points_sent;
  bit      send_gaps;
  bit      recv_stalls;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Result-side backpressure: random stall bursts while enabled
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (recv_stalls && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] ratio_of(int i);
    logic [63:0] num;
    logic [63:0] den;
    num = 64'(i + 1) * 64'(i + 1);
    den = 64'(i) * 64'(i);
    if (den == 64'd0) den = 64'd1;
    return (num << FRAC) / den;
  endfunction

  // Exact three-term sum, one arithmetic shift, then saturate to signed 48 bits.
  // 128-bit modular arithmetic holds the two's complement of the exact sum.
  function automatic logic [COEF_W-1:0] cn_rhs(logic [CONC_W-1:0] c1, logic [CONC_W-1:0] c2,
                                               logic [CONC_W-1:0] c3, logic [CONC_W-1:0] prev,
                                               logic [CONC_W-1:0] cur, logic [CONC_W-1:0] nxt);
    logic [127:0] acc;
    logic signed [127:0] sh;
    acc = 128'(c1) * 128'(prev) + 128'(c3) * 128'(nxt)
        - (128'(c1) + 128'(c3) - 128'(c2)) * 128'(cur);
    sh = $signed(acc) >>> FRAC;
    if (sh > SAT_HI) return {1'b0, {47{1'b1}}};
    if (sh < SAT_LO) return {1'b1, 47'd0};
    return sh[COEF_W-1:0];
  endfunction

  // Queue the rows that one accepted grid point produces, then advance the window
  task automatic crank_nicolson_rows(logic [CONC_W-1:0] a, logic [CONC_W-1:0] b);
    cn_row_t r;
    logic [127:0] prod;
    logic [CONC_W-1:0] c3;
    logic [CONC_W+1:0] dsum;
    int k;
    k = next_point;
    if (k == 0) begin
      // opening zero-flux row
      r.row = '0;
      r.lower = '0;
      r.diag = ONE_Q;
      r.upper = COEF_W'(0) - ONE_Q;
      r.rhs_a = '0;
      r.rhs_b = '0;
      r.last = 1'b0;
      rows_due.push_back(r);
    end else if (k >= 2) begin
      prod = (128'(diff_coeff) * 128'(ratio_of(k - 1))) >> FRAC;
      c3 = (prod > 128'(CONC_TOP)) ? CONC_TOP : prod[CONC_W-1:0];
      dsum = (CONC_W+2)'(diff_coeff) + (CONC_W+2)'(inv_dt) + (CONC_W+2)'(c3);
      r.row = ROW_W'(k - 1);
      r.lower = COEF_W'(0) - COEF_W'(diff_coeff);
      r.diag = (dsum > (CONC_W+2)'(CONC_TOP)) ? COEF_W'(CONC_TOP) : COEF_W'(dsum);
      r.upper = COEF_W'(0) - COEF_W'(c3);
      r.rhs_a = cn_rhs(diff_coeff, inv_dt, c3, a_older, a_newer, a);
      r.rhs_b = cn_rhs(diff_coeff, inv_dt, c3, b_older, b_newer, b);
      r.last = 1'b0;
      rows_due.push_back(r);
      if (k + 1 == GRID) begin
        // closing zero-flux row
        r.row = ROW_W'(k);
        r.lower = COEF_W'(0) - ONE_Q;
        r.diag = ONE_Q;
        r.upper = '0;
        r.rhs_a = '0;
        r.rhs_b = '0;
        r.last = 1'b1;
        rows_due.push_back(r);
      end
    end
    a_older = a_newer;
    a_newer = a;
    b_older = b_newer;
    b_newer = b;
    if (k + 1 >= GRID) begin
      next_point = 0;
      grids_done++;
    end else begin
      next_point = k + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, int row, logic [COEF_W-1:0] want,
                             logic [COEF_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch on row %0d: expected %h, actual %h",
               $time, name, row, want, got);
      mismatch_count++;
    end
  endtask

  // Compare every result transaction with the oldest pending row
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (rows_due.size() == 0) begin
        $display("%0t ns: unexpected row: expected none, actual row %0d",
                 $time, out_ch.row_index);
        mismatch_count++;
      end else begin
        row_want = rows_due.pop_front();
        check_field("row_index", int'(row_want.row), COEF_W'(row_want.row),
                    COEF_W'(out_ch.row_index));
        check_field("lower_coeff", int'(row_want.row), row_want.lower, out_ch.lower_coeff);
        check_field("diag_coeff", int'(row_want.row), row_want.diag, out_ch.diag_coeff);
        check_field("upper_coeff", int'(row_want.row), row_want.upper, out_ch.upper_coeff);
        check_field("rhs_a", int'(row_want.row), row_want.rhs_a, out_ch.rhs_a);
        check_field("rhs_b", int'(row_want.row), row_want.rhs_b, out_ch.rhs_b);
        check_field("last_row", int'(row_want.row), COEF_W'(row_want.last),
                    COEF_W'(out_ch.last_row));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Present one grid point; return after the transaction has been accepted.
  // valid stays high afterwards so back-to-back points need no extra cycle.
  task automatic send_point(logic [CONC_W-1:0] a, logic [CONC_W-1:0] b);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.conc_a <= a;
    in_ch.conc_b <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    crank_nicolson_rows(a, b);
    points_sent++;
  endtask

  // Drop valid, wait for every pending row, then let a point that produces no
  // row finish its work before anything else touches the block
  task automatic quiesce();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready
  task automatic apb_transfer(bit wr, int idx, logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= APB_ADDR_W'(idx * 8);
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Write a register (bits above 46 are don't-care and get masked), read it back
  task automatic write_register(int idx, logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] rd;
    apb_transfer(1'b1, idx, value, rd);
    if (idx == REG_DIFFUSION) diff_coeff = value[CONC_W-1:0];
    else if (idx == REG_INV_DT) inv_dt = value[CONC_W-1:0];
    apb_transfer(1'b0, idx, '0, rd);
    check_field("register readback", idx, COEF_W'(value[CONC_W-1:0]), COEF_W'(rd[CONC_W-1:0]));
  endtask

  function automatic logic [APB_DATA_W-1:0] junk_high(logic [CONC_W-1:0] v);
    return {17'($urandom), v};
  endfunction

  function automatic logic [CONC_W-1:0] rand_wide();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[CONC_W-1:0];
  endfunction

  task automatic set_profile(cfg_profile_t p);
    logic [CONC_W-1:0] c1;
    logic [CONC_W-1:0] c2;
    case (p)
      CFG_TYPICAL: begin
        c1 = CONC_W'($urandom_range(0, 1 << 18));
        c2 = CONC_W'($urandom_range(1 << 16, 1 << 24));
      end
      CFG_RANDOM: begin
        c1 = rand_wide();
        c2 = rand_wide();
      end
      CFG_ALL_MAX: begin
        c1 = CONC_TOP;
        c2 = CONC_TOP;
      end
      CFG_ALL_ZERO: begin
        c1 = '0;
        c2 = '0;
      end
      CFG_HIGH_DIFFUSION: begin
        c1 = CONC_TOP;
        c2 = '0;
      end
      default: begin
        c1 = '0;
        c2 = CONC_TOP;
      end
    endcase
    write_register(REG_DIFFUSION, junk_high(c1));
    write_register(REG_INV_DT, junk_high(c2));
  endtask

  // Mostly full-range values, with zeros, maxima and physically small ones mixed in
  function automatic logic [CONC_W-1:0] rand_conc();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CONC_TOP;
      2, 3: return CONC_W'($urandom_range(0, 1 << 20));
      default: return rand_wide();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register values; opening row, silent second point, first interior rows
  task automatic test_reset_defaults();
    send_point('0, '0);
    send_point(CONC_TOP, CONC_TOP);
    send_point(CONC_TOP, '0);
    send_point('0, CONC_TOP);
    send_point(rand_wide(), rand_wide());
  endtask

  // Register extremes against extreme concentrations to hit every saturation path
  task automatic test_register_extremes();
    cfg_profile_t plist[4];
    plist = '{CFG_ALL_MAX, CFG_HIGH_DIFFUSION, CFG_HIGH_INV_DT, CFG_ALL_ZERO};
    foreach (plist[i]) begin
      quiesce();
      set_profile(plist[i]);
      send_point(CONC_TOP, CONC_TOP);
      send_point('0, CONC_TOP);
      send_point(CONC_TOP, '0);
    end
  endtask

  // Run to the end of the grid: last interior row, closing row, wrap into a new grid
  task automatic test_grid_wrap();
    int start;
    quiesce();
    set_profile(CFG_TYPICAL);
    send_gaps = 1'b1;
    recv_stalls = 1'b1;
    start = grids_done;
    while (grids_done == start || next_point < 3)
      send_point(rand_conc(), rand_conc());
  endtask

  // Random segments with random settings; idling switched per segment, none at the end
  task automatic test_random_traffic();
    int len;
    bit paused;
    bit quiet;
    paused = 1'b0;
    while (points_sent < RANDOM_TARGET) begin
      quiet = points_sent > RANDOM_TARGET - 150;
      if (!quiet && $urandom_range(0, 2) == 0) begin
        quiesce();
        set_profile(cfg_profile_t'($urandom_range(0, 5)));
      end
      send_gaps = !quiet && $urandom_range(0, 3) != 0;
      recv_stalls = !quiet && $urandom_range(0, 3) != 0;
      len = $urandom_range(20, 120);
      for (int i = 0; i < len; i++) begin
        send_point(rand_conc(), rand_conc());
        // hold the sender once until every pending row has drained
        if (!paused && i == len / 2) begin
          quiesce();
          paused = 1'b1;
        end
      end
    end
  endtask

  // Drive every input to a known value from time zero, then release reset
  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.conc_a = '0;
    in_ch.conc_b = '0;
    diff_coeff = '0;
    inv_dt = INV_DT_RESET;
    a_older = '0;
    a_newer = '0;
    b_older = '0;
    b_newer = '0;
    next_point = 0;
    grids_done = 0;
    mismatch_count = 0;
    points_sent = 0;
    send_gaps = 1'b0;
    recv_stalls = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_grid_wrap();
    test_random_traffic();
    quiesce();

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
